// ===== hdl/frlp_pkg.sv =====
// Shared types, codes and default sizes for the flash record log pointer block.
// Used by the controller, the datapath, the top level and the port checker.
package frlp_pkg;

  localparam int unsigned FLASH_BYTES_DEF  = 2097152;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;
  localparam int unsigned RECORD_BYTES_DEF = 32;
  localparam int unsigned MAX_DELETE_DEF   = 63;

  localparam int unsigned PTR_W  = 32;
  localparam int unsigned AMT_W  = 16;
  localparam int unsigned ADDR_W = 21;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CNT_W  = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_DONE  = 3'd0,
    CMD_ERASE = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_HIT   = 3'd4,
    CMD_MISS  = 3'd5
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch the input word
    logic step;    // produce one result word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;  // output register empty or being taken
    logic last;       // the word produced by this step ends the item
  } dp_status_t;

endpackage

// ===== hdl/frlp_ctrl.sv =====
// Controller for the flash record log pointer block: idle/busy sequencer.
// Depends on frlp_pkg for the command and status structs.
module frlp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frlp_pkg::dp_status_t status_i,
  output frlp_pkg::dp_cmd_t    cmd_o
);
  import frlp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.step   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // one result word per cycle while the output register has room
        cmd_o.step = status_i.slot_free;
        if (status_i.slot_free && status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/frlp_dp.sv =====
// Datapath for the flash record log pointer block: pointers, item latch,
// per-step result logic and the output register. Depends on frlp_pkg.
module frlp_dp #(
  parameter int unsigned FLASH_BYTES  = frlp_pkg::FLASH_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = frlp_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned RECORD_BYTES = frlp_pkg::RECORD_BYTES_DEF,
  parameter int unsigned MAX_DELETE   = frlp_pkg::MAX_DELETE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  frlp_pkg::dp_cmd_t             cmd_i,
  output frlp_pkg::dp_status_t          status_o,
  input  frlp_pkg::op_e                 op_i,
  input  logic [frlp_pkg::PTR_W-1:0]    new_rd_ptr_i,
  input  logic [frlp_pkg::PTR_W-1:0]    new_wr_ptr_i,
  input  logic [frlp_pkg::AMT_W-1:0]    amount_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output frlp_pkg::cmd_e                res_cmd_o,
  output logic [frlp_pkg::ADDR_W-1:0]   res_addr_o,
  output logic [frlp_pkg::IDX_W-1:0]    res_idx_o,
  output logic [frlp_pkg::CNT_W-1:0]    res_cnt_o,
  output logic                          res_last_o
);
  import frlp_pkg::*;

  localparam logic [PTR_W-1:0] FLASH_MASK = PTR_W'(FLASH_BYTES - 1);
  localparam logic [PTR_W-1:0] SEC_MASK   = PTR_W'(SECTOR_BYTES - 1);
  localparam logic [PTR_W-1:0] SEC_SIZE   = PTR_W'(SECTOR_BYTES);
  localparam logic [PTR_W-1:0] REC_SIZE   = PTR_W'(RECORD_BYTES);
  localparam int unsigned      REC_SH     = $clog2(RECORD_BYTES);
  localparam logic [CNT_W-1:0] MAX_DEL    = CNT_W'(MAX_DELETE);

  // pointers
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;

  // item latch
  op_e              op_q;
  logic [PTR_W-1:0] new_rd_q, new_wr_q;
  logic [PTR_W-1:0] sum_q;
  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             erased_q, erased_d;

  // output register
  logic             valid_q, valid_d;
  cmd_e             cmd_q, cmd_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;
  logic             last_q, last_d;

  logic [PTR_W-1:0] rd_addr, wr_addr, sum_addr, sum_idx, rd_next;
  logic [CNT_W-1:0] cnt_inc;
  logic             empty;

  assign rd_addr  = rd_ptr_q & FLASH_MASK;
  assign wr_addr  = wr_ptr_q & FLASH_MASK;
  assign sum_addr = sum_q & FLASH_MASK;
  assign sum_idx  = sum_addr >> REC_SH;
  assign rd_next  = rd_ptr_q + REC_SIZE;
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign empty    = (rd_ptr_q == wr_ptr_q);

  assign status_o.slot_free = !valid_q || res_ready_i;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    erased_d = erased_q;
    cmd_d    = CMD_DONE;
    addr_d   = '0;
    idx_d    = '0;
    ocnt_d   = '0;
    last_d   = 1'b1;
    case (op_q)
      OP_LOAD: begin
        rd_ptr_d = new_rd_q;
        wr_ptr_d = new_wr_q;
      end
      OP_APPEND: begin
        addr_d = wr_addr[ADDR_W-1:0];
        if (((wr_addr & SEC_MASK) == '0) && !erased_q) begin
          cmd_d    = CMD_ERASE;
          last_d   = 1'b0;
          erased_d = 1'b1;
          // drop the oldest sector if the read pointer sits in it
          if (!empty && ((rd_addr & ~SEC_MASK) == wr_addr)) begin
            rd_ptr_d = (rd_ptr_q & ~SEC_MASK) + SEC_SIZE;
          end
        end else begin
          cmd_d    = CMD_WRITE;
          wr_ptr_d = wr_ptr_q + REC_SIZE;
        end
      end
      OP_DELETE: begin
        if ((cnt_q != limit_q) && !empty) begin
          cmd_d    = CMD_CLEAR;
          addr_d   = rd_addr[ADDR_W-1:0];
          ocnt_d   = cnt_inc;
          last_d   = (cnt_inc == limit_q) || (rd_next == wr_ptr_q);
          cnt_d    = cnt_inc;
          rd_ptr_d = rd_next;
        end
      end
      default: begin
        if (empty || (sum_q >= wr_ptr_q)) begin
          cmd_d = CMD_MISS;
        end else begin
          cmd_d  = CMD_HIT;
          addr_d = sum_addr[ADDR_W-1:0];
          idx_d  = sum_idx[IDX_W-1:0];
        end
      end
    endcase
  end

  assign status_o.last = last_d;

  always_comb begin
    if (cmd_i.step) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q && !res_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      valid_q  <= 1'b0;
      cnt_q    <= '0;
      erased_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.accept) begin
        cnt_q    <= '0;
        erased_q <= 1'b0;
      end else if (cmd_i.step) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        cnt_q    <= cnt_d;
        erased_q <= erased_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_i;
      new_rd_q <= new_rd_ptr_i;
      new_wr_q <= new_wr_ptr_i;
      // pointer to the record amount places past the read pointer, compared when the item steps
      sum_q    <= rd_ptr_q + (PTR_W'(amount_i) << REC_SH);
      limit_q  <= (amount_i > AMT_W'(MAX_DELETE)) ? MAX_DEL : amount_i[CNT_W-1:0];
    end
    if (cmd_i.step) begin
      cmd_q  <= cmd_d;
      addr_q <= addr_d;
      idx_q  <= idx_d;
      ocnt_q <= ocnt_d;
      last_q <= last_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_cmd_o   = cmd_q;
  assign res_addr_o  = addr_q;
  assign res_idx_o   = idx_q;
  assign res_cnt_o   = ocnt_q;
  assign res_last_o  = last_q;

endmodule

// ===== hdl/flash_record_log_pointers.sv =====
// Top level of the flash record log pointer block: stream ports, controller
// and datapath. Depends on frlp_pkg, frlp_ctrl and frlp_dp.
//
//  port group  | dir | tuser            | tdata (low bit up)                      | tlast
//  s_axis      | in  | [1:0] operation  | [31:0] new_read_pointer,                | -
//              |     |                  | [63:32] new_write_pointer, [79:64] amount|
//  m_axis      | out | [2:0] command    | [20:0] flash_address, [36:21]           | last
//              |     |                  | record_index, [42:37] deleted_count     |
//
// One result word is made per cycle while the output register has room:
// one for load and lookup, one or two for append (erase, then write), one per
// cleared record for delete (up to MAX_DELETE), or a done word when none is
// cleared. The single output register sets the pace: a stall on m_axis holds
// the sequencer. Reset clears both pointers to zero; the next item is taken
// once the last word of the current one sits in the output register.
module flash_record_log_pointers #(
  parameter int unsigned FLASH_BYTES  = frlp_pkg::FLASH_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = frlp_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned RECORD_BYTES = frlp_pkg::RECORD_BYTES_DEF,
  parameter int unsigned MAX_DELETE   = frlp_pkg::MAX_DELETE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // new_read_pointer, new_write_pointer, amount
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // flash_address, record_index, deleted_count, pad
  output logic [2:0]  m_axis_tuser,   // command
  output logic        m_axis_tlast
);
  import frlp_pkg::*;

  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;
  cmd_e              res_cmd;
  logic [ADDR_W-1:0] res_addr;
  logic [IDX_W-1:0]  res_idx;
  logic [CNT_W-1:0]  res_cnt;

  frlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  frlp_dp #(
    .FLASH_BYTES  (FLASH_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .RECORD_BYTES (RECORD_BYTES),
    .MAX_DELETE   (MAX_DELETE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .op_i         (op_e'(s_axis_tuser)),
    .new_rd_ptr_i (s_axis_tdata[31:0]),
    .new_wr_ptr_i (s_axis_tdata[63:32]),
    .amount_i     (s_axis_tdata[79:64]),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_cmd_o    (res_cmd),
    .res_addr_o   (res_addr),
    .res_idx_o    (res_idx),
    .res_cnt_o    (res_cnt),
    .res_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = res_cmd;
  assign m_axis_tdata = {5'b0, res_cnt, res_idx, res_addr};

endmodule

// ===== hdl/frlp_checker.sv =====
// Port checker for the flash record log pointer block, bound to the top level.
// Depends on frlp_pkg for the result command codes.
module frlp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,   // flash_address, record_index, deleted_count, pad
  input logic [2:0]  m_axis_tuser,   // command
  input logic        m_axis_tlast
);
  import frlp_pkg::*;

  // a taken item closes the input until its last result word has been produced
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  a_count_only_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != CMD_CLEAR) |-> m_axis_tdata[42:37] == '0)
    else $error("deleted count outside a clear");

  a_index_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != CMD_HIT) |-> m_axis_tdata[36:21] == '0)
    else $error("record index outside a hit");

  // done, hit, miss and write end an item; erase never does
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == CMD_ERASE || m_axis_tuser > CMD_MISS)
      |-> !m_axis_tlast && (m_axis_tuser == CMD_ERASE))
    else $error("bad command or last flag on erase");

endmodule

bind flash_record_log_pointers frlp_checker u_frlp_checker (.*);

// ===== bench/flash_record_log_pointers_tb.sv =====
// Self-checking bench for flash_record_log_pointers: directed cases, stalls, random traffic.
// Keeps its own copy of the log pointers and checks every m_axis word against it.
// Depends on frlp_pkg and the flash_record_log_pointers top level.
`timescale 1ns / 1ps

module flash_record_log_pointers_tb;
  import frlp_pkg::*;

  localparam int unsigned SEC_LOW_MASK = SECTOR_BYTES_DEF - 1;

  typedef struct {
    cmd_e             cmd;
    bit [ADDR_W-1:0]  addr;
    bit [IDX_W-1:0]   idx;
    bit [CNT_W-1:0]   cnt;
    bit               last;
  } flash_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // shadow copy of the block's pointers
  bit [31:0]  log_rd;
  bit [31:0]  log_wr;
  flash_cmd_t flash_cmds_due[$];

  int send_idle_pct;
  int rx_stall_pct;
  int rx_hold_cycles;
  int fail_count;

  flash_record_log_pointers dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit [31:0] flash_addr(bit [31:0] ptr);
    return ptr % FLASH_BYTES_DEF;
  endfunction

  function automatic void book_cmd(cmd_e cmd, bit [31:0] addr, bit [31:0] idx,
                                   bit [CNT_W-1:0] cnt, bit last);
    flash_cmd_t c;
    c.cmd  = cmd;
    c.addr = addr[ADDR_W-1:0];
    c.idx  = idx[IDX_W-1:0];
    c.cnt  = cnt;
    c.last = last;
    flash_cmds_due.push_back(c);
  endfunction

  function automatic void predict_flash_cmds(op_e op, bit [31:0] new_rd, bit [31:0] new_wr,
                                             bit [15:0] amount);
    bit [31:0] wa;
    bit [31:0] ra;
    bit [31:0] p;
    int unsigned n;
    int unsigned cleared;
    case (op)
      OP_LOAD: begin
        log_rd = new_rd;
        log_wr = new_wr;
        book_cmd(CMD_DONE, 0, 0, 0, 1'b1);
      end
      OP_APPEND: begin
        wa = flash_addr(log_wr);
        ra = flash_addr(log_rd);
        if ((wa & SEC_LOW_MASK) == 0) begin
          book_cmd(CMD_ERASE, wa, 0, 0, 1'b0);
          // drop the oldest sector if the read pointer sits in it
          if (log_rd != log_wr && (ra & ~SEC_LOW_MASK) == wa)
            log_rd = (log_rd & ~SEC_LOW_MASK) + SECTOR_BYTES_DEF;
        end
        book_cmd(CMD_WRITE, wa, 0, 0, 1'b1);
        log_wr = log_wr + RECORD_BYTES_DEF;
      end
      OP_DELETE: begin
        n = (32'(amount) > MAX_DELETE_DEF) ? MAX_DELETE_DEF : 32'(amount);
        cleared = 0;
        while (cleared < n && log_rd != log_wr) begin
          cleared++;
          book_cmd(CMD_CLEAR, flash_addr(log_rd), 0, cleared[CNT_W-1:0],
                   cleared == n || log_rd + RECORD_BYTES_DEF == log_wr);
          log_rd = log_rd + RECORD_BYTES_DEF;
        end
        if (cleared == 0)
          book_cmd(CMD_DONE, 0, 0, 0, 1'b1);
      end
      default: begin
        p = log_rd + 32'(amount) * RECORD_BYTES_DEF;
        if (log_rd == log_wr || p >= log_wr) begin
          book_cmd(CMD_MISS, 0, 0, 0, 1'b1);
        end else begin
          book_cmd(CMD_HIT, flash_addr(p), flash_addr(p) / RECORD_BYTES_DEF, 0, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic send_word(op_e op, bit [31:0] new_rd, bit [31:0] new_wr, bit [15:0] amount);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amount, new_wr, new_rd};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    // book the item once this edge's output word has been checked
    #1;
    predict_flash_cmds(op, new_rd, new_wr, amount);
  endtask

  // Compare each word taken from m_axis with the oldest booked command.
  always @(posedge clk_i) begin
    flash_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (flash_cmds_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: cmd %0d addr %h idx %h cnt %0d last %b",
                   m_axis_tuser, m_axis_tdata[20:0], m_axis_tdata[36:21],
                   m_axis_tdata[42:37], m_axis_tlast);
      end else begin
        want = flash_cmds_due.pop_front();
        if (m_axis_tuser != want.cmd || m_axis_tdata[20:0] != want.addr ||
            m_axis_tdata[36:21] != want.idx || m_axis_tdata[42:37] != want.cnt ||
            m_axis_tlast != want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: want cmd %0d addr %h idx %h cnt %0d last %b",
                     want.cmd, want.addr, want.idx, want.cnt, want.last);
            $display("          got  cmd %0d addr %h idx %h cnt %0d last %b",
                     m_axis_tuser, m_axis_tdata[20:0], m_axis_tdata[36:21],
                     m_axis_tdata[42:37], m_axis_tlast);
          end
        end
      end
    end
  end

  // Receiver: a requested hold-off wins over random stalls.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic random_item();
    bit [31:0]   edge_ptr;
    bit [31:0]   new_rd;
    bit [31:0]   new_wr;
    bit [31:0]   records;
    bit [15:0]   amount;
    int unsigned pick;
    new_rd = $urandom;
    new_wr = $urandom;
    amount = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) begin
      edge_ptr = ($urandom_range(1) ? $urandom : 32'd0) & ~SEC_LOW_MASK;
      case ($urandom_range(3))
        0: ;
        1: begin
          new_wr = edge_ptr - RECORD_BYTES_DEF * $urandom_range(0, 4);
          new_rd = new_wr - RECORD_BYTES_DEF * $urandom_range(0, 300);
        end
        2: begin
          // near-full log: the next erase lands on the read sector or the one before it
          new_wr = edge_ptr - RECORD_BYTES_DEF * $urandom_range(0, 4);
          new_rd = edge_ptr - FLASH_BYTES_DEF + RECORD_BYTES_DEF * $urandom_range(0, 130);
        end
        default: begin
          new_wr = edge_ptr - RECORD_BYTES_DEF * $urandom_range(0, 2);
          new_rd = new_wr;
        end
      endcase
      send_word(OP_LOAD, new_rd, new_wr, amount);
    end else if (pick < 50) begin
      send_word(OP_APPEND, new_rd, new_wr, amount);
    end else if (pick < 72) begin
      pick = $urandom_range(9);
      if (pick < 7)
        amount = 16'($urandom_range(0, 8));
      else if (pick < 9)
        amount = 16'($urandom_range(9, MAX_DELETE_DEF));
      send_word(OP_DELETE, new_rd, new_wr, amount);
    end else if (pick < 95) begin
      records = (log_wr - log_rd) / RECORD_BYTES_DEF;
      if (records > 32'd65533)
        records = 32'd65533;
      if ($urandom_range(9) < 7)
        amount = 16'($urandom_range(0, records + 2));
      send_word(OP_LOOKUP, new_rd, new_wr, amount);
    end else begin
      send_word(op_e'($urandom_range(3)), new_rd, new_wr, amount);
    end
  endtask

  task automatic test_empty_log();
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_DELETE, 0, 0, 5);
    send_word(OP_APPEND, 0, 0, 0);
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_LOOKUP, 0, 0, 1);
  endtask

  task automatic test_pointer_wrap();
    send_word(OP_LOAD, 32'hFFFF_FFC0, 32'hFFFF_FFE0, 0);
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_APPEND, 0, 0, 0);
    send_word(OP_LOOKUP, 0, 0, 0);
    send_word(OP_DELETE, 0, 0, 16'(MAX_DELETE_DEF));
  endtask

  task automatic test_delete_clamp();
    send_word(OP_LOAD, 0, 100 * RECORD_BYTES_DEF, 0);
    send_word(OP_DELETE, 0, 0, 0);
    send_word(OP_DELETE, 0, 0, 16'hFFFF);
    send_word(OP_DELETE, 0, 0, 16'(MAX_DELETE_DEF));
  endtask

  task automatic test_sector_drop();
    send_word(OP_LOAD, 32'h0000_2040, 32'h0020_2000, 0);
    send_word(OP_APPEND, 0, 0, 0);
    send_word(OP_LOOKUP, 0, 0, 0);
    // an empty log keeps its read pointer through an erase
    send_word(OP_LOAD, 32'h0000_5000, 32'h0000_5000, 0);
    send_word(OP_APPEND, 0, 0, 0);
  endtask

  task automatic test_lookup_extremes();
    send_word(OP_LOAD, 0, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_LOAD, 32'hFFFF_FFFF, 0, 0);
    send_word(OP_LOOKUP, 0, 0, 0);
  endtask

  task automatic test_output_backpressure();
    send_word(OP_LOAD, 0, 32'h0000_2000, 0);
    rx_hold_cycles = 400;
    send_word(OP_DELETE, 0, 0, 16'(MAX_DELETE_DEF));
    repeat (12) random_item();
  endtask

  task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    repeat (items) random_item();
  endtask

  initial begin
    send_idle_pct  = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    fail_count     = 0;
    log_rd         = '0;
    log_wr         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_log();
    test_pointer_wrap();
    test_delete_clamp();
    test_sector_drop();
    test_lookup_extremes();
    test_output_backpressure();
    test_random_traffic(56, 0, 0);
    test_random_traffic(56, 64, 0);
    test_random_traffic(56, 0, 64);
    test_random_traffic(56, 17, 17);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (flash_cmds_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
